FILE: hdl/tsc_pkg.sv
package tsc_pkg;

	// Record timestamps sit on a one-minute grid.
	localparam int unsigned STEP_SECONDS = 60;

	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	// Register word index on the configuration port.
	localparam logic REG_MAX_GAP  = 1'b0;
	localparam logic REG_END_TIME = 1'b1;

	// Classification of one record, lowest code first.
	typedef enum logic [2:0] {
		ST_GOOD       = 3'd0,
		ST_GAP        = 3'd1,
		ST_MISALIGNED = 3'd2,
		ST_OUT_BOUNDS = 3'd3,
		ST_BACKWARDS  = 3'd4,
		ST_GAP_LARGE  = 3'd5,
		ST_BAD_STEP   = 3'd6
	} status_t;

	// Saturating add of two 32-bit values.
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] sum;
		begin
			sum = {1'b0, a} + {1'b0, b};
			sat_add = sum[32] ? ALL_ONES : sum[31:0];
		end
	endfunction

	// True when the value is a multiple of 60: low two bits clear and a
	// multiple of 15, found by folding hex digits (16 is 1 modulo 15).
	function automatic logic on_grid(input logic [31:0] v);
		logic [6:0] digit_sum;
		logic [4:0] fold;
		begin
			digit_sum = 7'd0;
			for (int i = 0; i < 8; i++) begin
				digit_sum = digit_sum + {3'd0, v[4*i +: 4]};
			end
			fold = {2'd0, digit_sum[6:4]} + {1'b0, digit_sum[3:0]};
			on_grid = (v[1:0] == 2'b00) && ((fold == 5'd0) || (fold == 5'd15));
		end
	endfunction

endpackage

FILE: hdl/timestamp_sequence_checker_core.sv
// A stamp beat accepted into the input register is loaded into the result register once
// that register is free, and is presented from then on. Throughput: one stamp per cycle
// while the result side does not stall; the sequence state is updated in the same cycle
// that the result register loads, so each record sees the state left by the one before.
// Reset (arst_n low) clears all counters, the start and last times and both valid flags;
// max_gap resets to 0 and end_time to all ones.
module timestamp_sequence_checker_core (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Stamp channel
	input  logic        stamp_valid,
	output logic        stamp_stall,
	input  logic [31:0] stamp,
	// Result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic        keep,
	output logic [31:0] gap_length,
	output logic        end_before_start,
	output logic [31:0] record_count,
	output logic [31:0] error_count,
	output logic [31:0] gap_count,
	output logic [31:0] gap_span,
	output logic [31:0] longest_gap,
	output logic [31:0] start_stamp,
	output logic [31:0] last_stamp
);

	logic [31:0] max_gap_q;
	logic [31:0] end_time_q;

	logic [31:0] start_time_q;
	logic [31:0] prev_time_q;
	logic [31:0] records_q;
	logic [31:0] errors_q;
	logic [31:0] gaps_q;
	logic [31:0] gap_total_q;
	logic [31:0] gap_max_q;

	logic        valid_s1;
	logic [31:0] stamp_s1;

	logic              valid_s2;
	tsc_pkg::status_t  status_s2;
	logic              keep_s2;
	logic [31:0]       gap_len_s2;
	logic              ebs_s2;

	logic              advance;
	logic              load;
	logic              have_prev;
	logic [31:0]       diff;
	logic [31:0]       start_eff;
	logic              ebs;
	tsc_pkg::status_t  status_c;
	logic              keep_c;
	logic              take_stamp;
	logic              track_max;

	// Configuration writes; the byte offset within a word is ignored.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q  <= 32'd0;
			end_time_q <= tsc_pkg::ALL_ONES;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				tsc_pkg::REG_MAX_GAP:  max_gap_q  <= pwdata;
				tsc_pkg::REG_END_TIME: end_time_q <= pwdata;
				default: ;
			endcase
		end
	end

	assign prdata = (paddr[2] == tsc_pkg::REG_END_TIME) ? end_time_q : max_gap_q;

	// Pipeline flow: the input register moves on whenever the result register is free.
	assign advance     = !valid_s2 || !result_stall;
	assign load        = valid_s1 && advance;
	assign stamp_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!stamp_stall) begin
				valid_s1 <= stamp_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stamp_valid && !stamp_stall) begin
			stamp_s1 <= stamp;
		end
	end

	// Classification of the record in the input register against the current state.
	assign have_prev = (prev_time_q != 32'd0);
	assign diff      = have_prev ? (stamp_s1 - prev_time_q) : 32'd0;
	assign start_eff = have_prev ? start_time_q : stamp_s1;
	assign ebs       = !have_prev && (stamp_s1 > end_time_q);

	always_comb begin
		status_c   = tsc_pkg::ST_GOOD;
		keep_c     = 1'b0;
		take_stamp = 1'b0;
		track_max  = 1'b0;
		if (!tsc_pkg::on_grid(stamp_s1)) begin
			status_c = tsc_pkg::ST_MISALIGNED;
		end else if ((stamp_s1 < start_eff) || (stamp_s1 > end_time_q)) begin
			status_c = tsc_pkg::ST_OUT_BOUNDS;
		end else if (have_prev && (stamp_s1 < prev_time_q)) begin
			status_c = tsc_pkg::ST_BACKWARDS;
		end else if (have_prev && (max_gap_q != 32'd0) && (diff > max_gap_q)) begin
			status_c  = tsc_pkg::ST_GAP_LARGE;
			track_max = 1'b1;
		end else if (have_prev && (diff > 32'(tsc_pkg::STEP_SECONDS))) begin
			status_c   = tsc_pkg::ST_GAP;
			track_max  = 1'b1;
			take_stamp = 1'b1;
			keep_c     = 1'b1;
		end else if (have_prev && (diff != 32'(tsc_pkg::STEP_SECONDS))) begin
			status_c   = tsc_pkg::ST_BAD_STEP;
			take_stamp = 1'b1;
		end else begin
			status_c   = tsc_pkg::ST_GOOD;
			take_stamp = 1'b1;
			keep_c     = 1'b1;
		end
	end

	// Sequence state, updated as each result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= 32'd0;
			prev_time_q  <= 32'd0;
			records_q    <= 32'd0;
			errors_q     <= 32'd0;
			gaps_q       <= 32'd0;
			gap_total_q  <= 32'd0;
			gap_max_q    <= 32'd0;
		end else if (load) begin
			records_q <= tsc_pkg::sat_add(records_q, 32'd1);
			if (!have_prev) begin
				start_time_q <= stamp_s1;
			end
			if (take_stamp) begin
				prev_time_q <= stamp_s1;
			end
			if (track_max && (diff > gap_max_q)) begin
				gap_max_q <= diff;
			end
			if (status_c == tsc_pkg::ST_GAP) begin
				gaps_q      <= tsc_pkg::sat_add(gaps_q, 32'd1);
				gap_total_q <= tsc_pkg::sat_add(gap_total_q, diff);
			end
			if (!((status_c == tsc_pkg::ST_GOOD) || (status_c == tsc_pkg::ST_GAP))) begin
				errors_q <= tsc_pkg::sat_add(errors_q, 32'd1);
			end
		end
	end

	// Result register for the per-record fields.
	always_ff @(posedge clk) begin
		if (load) begin
			status_s2  <= status_c;
			keep_s2    <= keep_c;
			gap_len_s2 <= diff;
			ebs_s2     <= ebs;
		end
	end

	// The running totals are the state itself: it only changes when a new result loads.
	assign result_valid     = valid_s2;
	assign status           = status_s2;
	assign keep             = keep_s2;
	assign gap_length       = gap_len_s2;
	assign end_before_start = ebs_s2;
	assign record_count     = records_q;
	assign error_count      = errors_q;
	assign gap_count        = gaps_q;
	assign gap_span         = gap_total_q;
	assign longest_gap      = gap_max_q;
	assign start_stamp      = start_time_q;
	assign last_stamp       = prev_time_q;

	// The totals of a stalled result beat must not move under it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> ($stable(error_count) && $stable(last_stamp)))
		else $error("sequence state changed while a result beat was stalled");

	// The last accepted time moves only when a record is loaded.
	assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> $stable(last_stamp))
		else $error("last_stamp changed without a record");

	// The record counter never goes backwards.
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (record_count >= $past(record_count)))
		else $error("record_count decreased");

	// Only good and gap records are kept.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (keep == ((status == tsc_pkg::ST_GOOD) || (status == tsc_pkg::ST_GAP))))
		else $error("keep disagrees with status");

	// An ordinary gap is always longer than one step.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (status == tsc_pkg::ST_GAP))
			|-> (gap_length > 32'(tsc_pkg::STEP_SECONDS)))
		else $error("gap status with a short gap");

endmodule

FILE: test/tb_timestamp_sequence_checker_core.sv
`timescale 1ns / 100ps

module tb_timestamp_sequence_checker_core;

	// One expected result beat, field for field.
	typedef struct {
		tsc_pkg::status_t status;
		logic        keep;
		logic [31:0] gap_length;
		logic        end_before_start;
		logic [31:0] record_count;
		logic [31:0] error_count;
		logic [31:0] gap_count;
		logic [31:0] gap_span;
		logic [31:0] longest_gap;
		logic [31:0] start_stamp;
		logic [31:0] last_stamp;
	} record_verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        stamp_valid = 1'b0;
	logic        stamp_stall;
	logic [31:0] stamp = 32'd0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  status;
	logic        keep;
	logic [31:0] gap_length;
	logic        end_before_start;
	logic [31:0] record_count;
	logic [31:0] error_count;
	logic [31:0] gap_count;
	logic [31:0] gap_span;
	logic [31:0] longest_gap;
	logic [31:0] start_stamp;
	logic [31:0] last_stamp;

	// Mirror of the configuration and of the sequence bookkeeping.
	logic [31:0] cfg_max_gap = 32'd0;
	logic [31:0] cfg_end_time = tsc_pkg::ALL_ONES;
	logic [31:0] start_time_q = 32'd0;
	logic [31:0] last_time_q = 32'd0;
	logic [31:0] seen_q = 32'd0;
	logic [31:0] faults_q = 32'd0;
	logic [31:0] gaps_q = 32'd0;
	logic [31:0] span_q = 32'd0;
	logic [31:0] widest_gap_q = 32'd0;

	record_verdict_t pending_verdicts[$];

	int unsigned mismatch_total = 0;
	int unsigned stamps_sent = 0;
	int unsigned verdicts_checked = 0;
	int unsigned register_writes = 0;
	int unsigned status_hits[7];
	int unsigned hold_request = 0;
	bit          idle_off = 1'b0;

	timestamp_sequence_checker_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.stamp_valid(stamp_valid),
		.stamp_stall(stamp_stall),
		.stamp(stamp),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status(status),
		.keep(keep),
		.gap_length(gap_length),
		.end_before_start(end_before_start),
		.record_count(record_count),
		.error_count(error_count),
		.gap_count(gap_count),
		.gap_span(gap_span),
		.longest_gap(longest_gap),
		.start_stamp(start_stamp),
		.last_stamp(last_stamp)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatch_total++;
	endtask

	function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] total;
		total = {1'b0, a} + {1'b0, b};
		return total[32] ? tsc_pkg::ALL_ONES : total[31:0];
	endfunction

	// Classify one stamp and advance the mirrored bookkeeping.
	function automatic record_verdict_t classify_stamp(input logic [31:0] value);
		record_verdict_t v;
		logic have_last;
		logic [31:0] diff;
		have_last = (last_time_q != 32'd0);
		diff = have_last ? value - last_time_q : 32'd0;
		v.keep = 1'b0;
		v.end_before_start = 1'b0;
		v.gap_length = diff;
		seen_q = clamp_add(seen_q, 32'd1);
		// With no accepted time yet, every stamp restarts the sequence.
		if (!have_last) begin
			start_time_q = value;
			v.end_before_start = (value > cfg_end_time);
		end
		if (value % tsc_pkg::STEP_SECONDS != 0) begin
			v.status = tsc_pkg::ST_MISALIGNED;
		end else if (value < start_time_q || value > cfg_end_time) begin
			v.status = tsc_pkg::ST_OUT_BOUNDS;
		end else if (have_last && value < last_time_q) begin
			v.status = tsc_pkg::ST_BACKWARDS;
		end else if (have_last && cfg_max_gap != 32'd0 && diff > cfg_max_gap) begin
			v.status = tsc_pkg::ST_GAP_LARGE;
			if (diff > widest_gap_q) widest_gap_q = diff;
		end else if (have_last && diff > tsc_pkg::STEP_SECONDS) begin
			v.status = tsc_pkg::ST_GAP;
			if (diff > widest_gap_q) widest_gap_q = diff;
			gaps_q = clamp_add(gaps_q, 32'd1);
			span_q = clamp_add(span_q, diff);
			last_time_q = value;
			v.keep = 1'b1;
		end else if (have_last && diff != tsc_pkg::STEP_SECONDS) begin
			v.status = tsc_pkg::ST_BAD_STEP;
			last_time_q = value;
		end else begin
			v.status = tsc_pkg::ST_GOOD;
			last_time_q = value;
			v.keep = 1'b1;
		end
		if (v.status >= tsc_pkg::ST_MISALIGNED) faults_q = clamp_add(faults_q, 32'd1);
		v.record_count = seen_q;
		v.error_count = faults_q;
		v.gap_count = gaps_q;
		v.gap_span = span_q;
		v.longest_gap = widest_gap_q;
		v.start_stamp = start_time_q;
		v.last_stamp = last_time_q;
		return v;
	endfunction

	// Mostly a well-formed minute sequence, with gaps, repeats and noise mixed in.
	function automatic logic [31:0] draw_stamp();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return last_time_q + tsc_pkg::STEP_SECONDS;
		if (pick < 68) return last_time_q + tsc_pkg::STEP_SECONDS * $urandom_range(2, 8);
		if (pick < 74) return last_time_q + tsc_pkg::STEP_SECONDS * $urandom_range(9, 40);
		if (pick < 79) return last_time_q;
		if (pick < 85) return last_time_q + $urandom_range(1, 59);
		if (pick < 91) return last_time_q - tsc_pkg::STEP_SECONDS * $urandom_range(1, 5);
		if (pick < 95)
			return (cfg_end_time / tsc_pkg::STEP_SECONDS + 1) * tsc_pkg::STEP_SECONDS;
		return $urandom();
	endfunction

	// Offer one stamp beat and predict its result once it is taken.
	task automatic send_stamp(input logic [31:0] value);
		int unsigned gap;
		gap = idle_off ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			stamp_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stamp_valid <= 1'b1;
		stamp <= value;
		@(posedge clk);
		while (stamp_stall) @(posedge clk);
		pending_verdicts.push_back(classify_stamp(value));
		stamps_sent++;
	endtask

	// Stop offering, let every pending result come out, then wait with the input idle.
	task automatic drain_results();
		stamp_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register, then read it back.
	task automatic write_register(input logic index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (index == tsc_pkg::REG_MAX_GAP) cfg_max_gap = value;
		else cfg_end_time = value;
		register_writes++;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== value)
			report_mismatch($sformatf("register %0d reads %h, written %h", index, prdata, value));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d field %s: got %h, expected %h",
				verdicts_checked, name, got, want));
	endtask

	// Result side: take beats, compare with the oldest prediction, stall at random.
	initial begin : result_monitor
		int unsigned hold_left;
		record_verdict_t want;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				verdicts_checked++;
				if (pending_verdicts.size() == 0) begin
					report_mismatch("result beat with no prediction pending");
				end else begin
					want = pending_verdicts.pop_front();
					status_hits[want.status]++;
					check_field("status", {29'd0, status}, {29'd0, want.status});
					check_field("keep", {31'd0, keep}, {31'd0, want.keep});
					check_field("gap_length", gap_length, want.gap_length);
					check_field("end_before_start", {31'd0, end_before_start},
						{31'd0, want.end_before_start});
					check_field("record_count", record_count, want.record_count);
					check_field("error_count", error_count, want.error_count);
					check_field("gap_count", gap_count, want.gap_count);
					check_field("gap_span", gap_span, want.gap_span);
					check_field("longest_gap", longest_gap, want.longest_gap);
					check_field("start_stamp", start_stamp, want.start_stamp);
					check_field("last_stamp", last_stamp, want.last_stamp);
				end
				hold_left = idle_off ? 0 : $urandom_range(0, 4);
			end
			// A long hold-off requested by a test is counted down here.
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Start times taken while nothing has been accepted, against a low end time.
	task automatic test_restart_bounds();
		write_register(tsc_pkg::REG_END_TIME, 32'd1000);
		send_stamp(32'd1200);
		send_stamp(32'd1260);
		send_stamp(32'd7);
		send_stamp(32'd0);
		send_stamp(tsc_pkg::ALL_ONES);
		drain_results();
	endtask

	// Stamps for every classification but the large gap, under the reset configuration.
	task automatic test_each_status();
		write_register(tsc_pkg::REG_END_TIME, tsc_pkg::ALL_ONES);
		send_stamp(32'd60);
		send_stamp(32'd120);
		send_stamp(32'd121);
		send_stamp(32'd30);
		send_stamp(32'd600);
		send_stamp(32'd540);
		send_stamp(32'd600);
		send_stamp(32'd0);
		send_stamp(32'd660);
		send_stamp(tsc_pkg::ALL_ONES);
		drain_results();
	endtask

	// Gap limit at and just past its edge, then the extreme register values.
	task automatic test_gap_limit();
		write_register(tsc_pkg::REG_MAX_GAP, 32'd120);
		send_stamp(32'd780);
		send_stamp(32'd960);
		send_stamp(32'd840);
		drain_results();
		write_register(tsc_pkg::REG_END_TIME, 32'd0);
		write_register(tsc_pkg::REG_MAX_GAP, tsc_pkg::ALL_ONES);
		send_stamp(32'd900);
		send_stamp(32'd0);
		drain_results();
	endtask

	task automatic test_random_phase(input logic [31:0] gap_limit, input logic [31:0] end_limit,
			input int unsigned count);
		write_register(tsc_pkg::REG_MAX_GAP, gap_limit);
		write_register(tsc_pkg::REG_END_TIME, end_limit);
		repeat (count) send_stamp(draw_stamp());
		drain_results();
	endtask

	// Receiver holds off while the sender keeps offering, so the input stalls.
	task automatic test_backpressure();
		idle_off = 1'b1;
		hold_request = 60;
		repeat (30) send_stamp(draw_stamp());
		drain_results();
		repeat (40) send_stamp(draw_stamp());
		idle_off = 1'b0;
		drain_results();
	endtask

	// Sender pauses until every result is back, then carries on.
	task automatic test_sender_pause();
		repeat (15) send_stamp(draw_stamp());
		stamp_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		@(posedge clk);
		repeat (15) send_stamp(draw_stamp());
		drain_results();
	endtask

	// Top of the 32-bit range: largest grid stamp, all ones, and a repeat.
	task automatic test_top_of_range();
		write_register(tsc_pkg::REG_MAX_GAP, 32'd0);
		write_register(tsc_pkg::REG_END_TIME, tsc_pkg::ALL_ONES);
		send_stamp(32'hFFFF_FFF0);
		send_stamp(tsc_pkg::ALL_ONES);
		send_stamp(32'hFFFF_FFF0);
		drain_results();
	endtask

	initial begin : sequencer
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_restart_bounds();
		test_each_status();
		test_gap_limit();
		test_random_phase(32'd0, tsc_pkg::ALL_ONES, 220);
		test_random_phase(32'd300, last_time_q + tsc_pkg::STEP_SECONDS * 1500, 180);
		test_backpressure();
		test_sender_pause();
		test_random_phase(tsc_pkg::ALL_ONES, tsc_pkg::ALL_ONES, 100);
		test_random_phase($urandom_range(60, 1200), last_time_q + $urandom_range(0, 200000), 100);
		test_top_of_range();
		repeat (10) @(posedge clk);
		if (pending_verdicts.size() != 0)
			report_mismatch($sformatf("%0d predictions never matched", pending_verdicts.size()));
		$display("Sent %0d stamps, checked %0d results, %0d register writes.",
			stamps_sent, verdicts_checked, register_writes);
		$display("Status mix: good %0d gap %0d misaligned %0d bounds %0d back %0d large %0d step %0d",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3],
			status_hits[4], status_hits[5], status_hits[6]);
		if (mismatch_total == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Hard stop if the handshakes ever hang.
	initial begin : watchdog
		#(2_000_000);
		$display("Timed out waiting for the block.");
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
hdl/tsc_pkg.sv
hdl/timestamp_sequence_checker_core.sv
test/tb_timestamp_sequence_checker_core.sv
